// File: design/bitmap_page_frame_allocator_assert.svh
// Assertion macros for the page frame allocator.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// Checked outside reset.
`define BPFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define BPFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPFA_ASSERT(lbl, prop, msg)
`define BPFA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: design/bpfa_pkg.sv
// Shared constants and controller/datapath types for the page frame allocator.
package bpfa_pkg;
  localparam int ADDR_W = 48;
  localparam int OP_W   = 3;

  localparam logic [OP_W-1:0] OP_INIT      = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK_USED = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd4;

  // write data selection for the bitmap store
  localparam logic [1:0] WS_ONES  = 2'd0;
  localparam logic [1:0] WS_RANGE = 2'd1;
  localparam logic [1:0] WS_ALLOC = 2'd2;
  localparam logic [1:0] WS_FREE  = 2'd3;

  typedef struct packed {
    logic       ld_item;
    logic       setup1;
    logic       setup2;
    logic       ptr_zero;
    logic       ptr_first;
    logic       ptr_inc;
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] wsel;
    logic       cnt_load;
    logic       cnt_dec;
    logic       cnt_inc;
    logic       alloc_hit;
    logic       set_oom;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            skip;
    logic            free_beyond;
    logic            at_range_end;
    logic            at_last_word;
    logic            hit;
    logic            hit_zero;
    logic            out_free;
  } sts_t;
endpackage

// File: design/bpfa_if.sv
// Valid/ready channel interfaces for requests and results.
interface bpfa_item_if;
  logic                          valid;
  logic                          ready;
  logic [bpfa_pkg::OP_W-1:0]     operation;
  logic [bpfa_pkg::ADDR_W-1:0]   address;
  logic [bpfa_pkg::ADDR_W-1:0]   length;
  modport source (output valid, operation, address, length, input ready);
  modport sink (input valid, operation, address, length, output ready);
endinterface

interface bpfa_result_if;
  logic                          valid;
  logic                          ready;
  logic [bpfa_pkg::ADDR_W-1:0]   page_address;
  logic                          out_of_memory;
  logic                          out_of_range;
  logic [bpfa_pkg::ADDR_W-1:0]   free_bytes;
  modport source (output valid, page_address, out_of_memory, out_of_range, free_bytes,
                  input ready);
  modport sink (input valid, page_address, out_of_memory, out_of_range, free_bytes,
                output ready);
endinterface

// File: design/bpfa_datapath.sv
// Datapath: bitmap store, range and search logic, free counter, result register.
module bpfa_datapath #(
  parameter int PAGE_SHIFT = 12,
  parameter int NUM_PAGES  = 65536,
  parameter int WORD_BITS  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bpfa_pkg::ADDR_W-1:0] cfg_wr_data,
  input  logic [bpfa_pkg::OP_W-1:0]   operation,
  input  logic [bpfa_pkg::ADDR_W-1:0] address,
  input  logic [bpfa_pkg::ADDR_W-1:0] length,
  input  bpfa_pkg::cmd_t              cmd,
  output bpfa_pkg::sts_t              sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bpfa_pkg::ADDR_W-1:0] page_address,
  output logic                        out_of_memory,
  output logic                        out_of_range,
  output logic [bpfa_pkg::ADDR_W-1:0] free_bytes
);
  localparam int AW        = bpfa_pkg::ADDR_W;
  localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int PI_W      = $clog2(NUM_PAGES);
  localparam int PAGE_W    = AW - PAGE_SHIFT;
  localparam int LAST_BITS = NUM_PAGES - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] ONES      = '1;
  localparam logic [WORD_BITS-1:0] LAST_MASK = ONES >> (WORD_BITS - LAST_BITS);
  localparam logic [AW-1:0] PAGE_BYTES = {{(AW-1){1'b0}}, 1'b1} << PAGE_SHIFT;

  logic [bpfa_pkg::OP_W-1:0] op_r;
  logic [AW-1:0]             addr_r;
  logic [AW-1:0]             len_r;
  logic [PAGE_W:0]           cnt_r;
  logic [PI_W-1:0]           first_idx;
  logic [PI_W-1:0]           last_idx;
  logic [WIDX_W-1:0]         wptr;
  logic [BIT_W-1:0]          bit_r;
  logic [WORD_BITS-1:0]      rdata;
  logic                      oom_r;
  logic                      oor_r;
  logic                      hit_r;
  logic [AW-1:0]             ctr;
  logic [AW-1:0]             init_free;
  logic [WORD_BITS-1:0]      mem [NUM_WORDS];

  logic [PAGE_W-1:0]    first_full;
  logic                 first_beyond;
  logic [AW:0]          len_sum;
  logic [PAGE_W+1:0]    last_full;
  logic                 range_empty;
  logic                 beyond;
  logic [WIDX_W-1:0]    first_word;
  logic [WIDX_W-1:0]    last_word;
  logic [BIT_W-1:0]     lo_bit;
  logic [BIT_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] rmask;
  logic [WORD_BITS-1:0] inv;
  logic [BIT_W-1:0]     enc;
  logic [WORD_BITS-1:0] bit_oh;
  logic [WORD_BITS-1:0] wdata;
  logic [AW-1:0]        ctr_dec;
  logic [AW:0]          inc_sum;
  logic [AW-1:0]        ctr_inc;

  assign first_full   = addr_r[AW-1:PAGE_SHIFT];
  assign first_beyond = first_full >= PAGE_W'(NUM_PAGES);
  assign len_sum      = {1'b0, len_r} + {1'b0, PAGE_BYTES - {{(AW-1){1'b0}}, 1'b1}};
  assign last_full    = {2'b00, first_full} + {1'b0, cnt_r} - (PAGE_W+2)'(1);
  assign range_empty  = (cnt_r == '0);
  assign beyond       = last_full >= (PAGE_W+2)'(NUM_PAGES);
  assign first_word   = WIDX_W'(first_idx >> BIT_W);
  assign last_word    = WIDX_W'(last_idx >> BIT_W);

  // range mask within the current word
  assign lo_bit = (wptr == first_word) ? first_idx[BIT_W-1:0] : '0;
  assign hi_bit = (wptr == last_word) ? last_idx[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
  assign rmask  = (ONES << lo_bit) & (ONES >> (BIT_W'(WORD_BITS - 1) - hi_bit));

  // lowest free bit of the word just read; bits past the last page never count
  assign inv = ~rdata & ((wptr == WIDX_W'(NUM_WORDS - 1)) ? LAST_MASK : ONES);

  always_comb begin
    enc = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (inv[b]) begin
        enc = BIT_W'(b);
      end
    end
  end

  assign bit_oh = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_r;

  always_comb begin
    case (cmd.wsel)
      bpfa_pkg::WS_ONES:  wdata = ONES;
      bpfa_pkg::WS_RANGE: wdata = (op_r == bpfa_pkg::OP_MARK_USED) ? (rdata | rmask)
                                                                  : (rdata & ~rmask);
      bpfa_pkg::WS_ALLOC: wdata = rdata | bit_oh;
      bpfa_pkg::WS_FREE:  wdata = rdata & ~bit_oh;
      default:            wdata = ONES;
    endcase
  end

  assign ctr_dec = (ctr >= PAGE_BYTES) ? (ctr - PAGE_BYTES) : '0;
  assign inc_sum = {1'b0, ctr} + {1'b0, PAGE_BYTES};
  assign ctr_inc = inc_sum[AW] ? '1 : inc_sum[AW-1:0];

  always_comb begin
    sts              = '0;
    sts.op           = op_r;
    sts.skip         = range_empty || first_beyond;
    sts.free_beyond  = first_beyond;
    sts.at_range_end = (wptr == last_word);
    sts.at_last_word = (wptr == WIDX_W'(NUM_WORDS - 1));
    sts.hit          = |inv;
    sts.hit_zero     = (wptr == '0) && (enc == '0);
    sts.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wptr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[wptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      op_r   <= operation;
      addr_r <= address;
      len_r  <= length;
      oom_r  <= 1'b0;
      oor_r  <= 1'b0;
      hit_r  <= 1'b0;
    end
    if (cmd.setup1) begin
      cnt_r <= len_sum[AW:PAGE_SHIFT];
    end
    if (cmd.setup2) begin
      first_idx <= first_full[PI_W-1:0];
      last_idx  <= beyond ? PI_W'(NUM_PAGES - 1) : last_full[PI_W-1:0];
      if (op_r == bpfa_pkg::OP_MARK_USED || op_r == bpfa_pkg::OP_MARK_FREE) begin
        oor_r <= !range_empty && beyond;
      end else if (op_r == bpfa_pkg::OP_FREE) begin
        oor_r <= first_beyond;
      end
    end
    if (cmd.ptr_first) begin
      bit_r <= first_full[BIT_W-1:0];
    end
    if (cmd.alloc_hit) begin
      bit_r <= enc;
      hit_r <= 1'b1;
    end
    if (cmd.set_oom) begin
      oom_r <= 1'b1;
    end
    if (cmd.res_load) begin
      page_address  <= hit_r ? (AW'({wptr, bit_r}) << PAGE_SHIFT) : '0;
      out_of_memory <= oom_r;
      out_of_range  <= oor_r;
      free_bytes    <= ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      ctr       <= '0;
      init_free <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        init_free <= cfg_wr_data;
      end
      if (cmd.ptr_zero) begin
        wptr <= '0;
      end else if (cmd.ptr_first) begin
        wptr <= WIDX_W'(first_full[PI_W-1:0] >> BIT_W);
      end else if (cmd.ptr_inc) begin
        wptr <= wptr + WIDX_W'(1);
      end
      if (cmd.cnt_load) begin
        ctr <= init_free;
      end else if (cmd.cnt_dec) begin
        ctr <= ctr_dec;
      end else if (cmd.cnt_inc) begin
        ctr <= ctr_inc;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// File: design/bpfa_ctrl.sv
// Controller state machine sequencing the bitmap datapath.
module bpfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bpfa_pkg::sts_t sts,
  output bpfa_pkg::cmd_t cmd
);
  localparam logic [3:0] S_BOOT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SETUP1   = 4'd2;
  localparam logic [3:0] S_SETUP2   = 4'd3;
  localparam logic [3:0] S_CLEAR    = 4'd4;
  localparam logic [3:0] S_RNG_RD   = 4'd5;
  localparam logic [3:0] S_RNG_WR   = 4'd6;
  localparam logic [3:0] S_SCAN_RD  = 4'd7;
  localparam logic [3:0] S_SCAN_CHK = 4'd8;
  localparam logic [3:0] S_ALLOC_WR = 4'd9;
  localparam logic [3:0] S_FREE_RD  = 4'd10;
  localparam logic [3:0] S_FREE_WR  = 4'd11;
  localparam logic [3:0] S_FIN      = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_BOOT, S_CLEAR: begin
        cmd.mem_wr = 1'b1;
        cmd.wsel   = bpfa_pkg::WS_ONES;
        if (sts.at_last_word) begin
          state_next = (state == S_BOOT) ? S_IDLE : S_FIN;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_next  = S_SETUP1;
        end
      end
      S_SETUP1: begin
        cmd.setup1 = 1'b1;
        state_next = S_SETUP2;
      end
      S_SETUP2: begin
        cmd.setup2 = 1'b1;
        case (sts.op)
          bpfa_pkg::OP_INIT: begin
            cmd.ptr_zero = 1'b1;
            cmd.cnt_load = 1'b1;
            state_next   = S_CLEAR;
          end
          bpfa_pkg::OP_MARK_USED, bpfa_pkg::OP_MARK_FREE: begin
            if (sts.skip) begin
              state_next = S_FIN;
            end else begin
              cmd.ptr_first = 1'b1;
              state_next    = S_RNG_RD;
            end
          end
          bpfa_pkg::OP_ALLOC: begin
            cmd.ptr_zero = 1'b1;
            state_next   = S_SCAN_RD;
          end
          bpfa_pkg::OP_FREE: begin
            if (sts.free_beyond) begin
              state_next = S_FIN;
            end else begin
              cmd.ptr_first = 1'b1;
              state_next    = S_FREE_RD;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_RNG_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_RNG_WR;
      end
      S_RNG_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.wsel   = bpfa_pkg::WS_RANGE;
        if (sts.at_range_end) begin
          state_next = S_FIN;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_RNG_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.hit) begin
          if (sts.hit_zero) begin
            cmd.set_oom = 1'b1;
            state_next  = S_FIN;
          end else begin
            cmd.alloc_hit = 1'b1;
            cmd.cnt_dec   = 1'b1;
            state_next    = S_ALLOC_WR;
          end
        end else if (sts.at_last_word) begin
          cmd.set_oom = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_ALLOC_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.wsel   = bpfa_pkg::WS_ALLOC;
        state_next = S_FIN;
      end
      S_FREE_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.mem_wr  = 1'b1;
        cmd.wsel    = bpfa_pkg::WS_FREE;
        cmd.cnt_inc = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
    end else begin
      state <= state_next;
    end
  end
endmodule

// File: design/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator.
// One used/free bit per page is held in a single-port memory of WORD_BITS-bit
// words (NUM_PAGES / WORD_BITS words, rounded up; WORD_BITS a power of two),
// beside a 48-bit free byte counter. One request is handled at a time and
// gives one result. After reset the store is swept to all-used, one word a
// cycle, so no request is taken until the sweep is done. The one memory port
// sets the cost of each request, as a word is read, then written back: init
// sweeps the whole store; mark range visits each word touched (none for an
// empty range or one wholly beyond the store); alloc scans from word 0 and
// writes back the word on a hit; free rewrites one word (none beyond the
// store); unknown codes touch no word; then the result is handed over.
// A finished result sits in an output register, so the next request is taken
// while it waits. The value written via cfg_wr_data is loaded into the counter by init only.
module bitmap_page_frame_allocator #(
  parameter int PAGE_SHIFT = 12,
  parameter int NUM_PAGES  = 65536,
  parameter int WORD_BITS  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [bpfa_pkg::ADDR_W-1:0] cfg_wr_data,
  bpfa_item_if.sink                   items,
  bpfa_result_if.source               results
);
  bpfa_pkg::cmd_t cmd;
  bpfa_pkg::sts_t sts;

  // sequencing: boot sweep, per-op walk, result hand-over
  bpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bitmap store, range masks, first-free search and counter
  bpfa_datapath #(
    .PAGE_SHIFT (PAGE_SHIFT),
    .NUM_PAGES  (NUM_PAGES),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .operation     (items.operation),
    .address       (items.address),
    .length        (items.length),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .page_address  (results.page_address),
    .out_of_memory (results.out_of_memory),
    .out_of_range  (results.out_of_range),
    .free_bytes    (results.free_bytes)
  );

`include "bitmap_page_frame_allocator_assert.svh"
  // one request in flight: a transfer in drops ready next cycle
  `BPFA_ASSERT(a_single_item, items.valid && items.ready |=> !items.ready, "second item taken")
  // failed alloc returns no page
  `BPFA_ASSERT(a_oom_no_page,
    results.valid && results.out_of_memory |-> results.page_address == '0, "page with oom")
  // allocated pages are page aligned
  `BPFA_ASSERT(a_page_aligned,
    results.valid |-> results.page_address[PAGE_SHIFT-1:0] == '0, "unaligned page")
  // no request is taken during the boot sweep
  `BPFA_ASSERT_ALWAYS(a_boot_blocks, rst |=> !items.ready, "ready after reset")
endmodule
